@@ rtl/overcurrent_retry_lockout_macros.svh @@
// Assertion macros used by the overcurrent retry lockout top level
`ifndef OVERCURRENT_RETRY_LOCKOUT_MACROS_SVH
`define OVERCURRENT_RETRY_LOCKOUT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ORL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ORL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/orl_pkg.sv @@
// Types, codes and reset constants for the overcurrent retry lockout block
package orl_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int ERR_W           = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERRORS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_WAIT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_WAIT  = 2'd3;

    localparam logic signed [15:0] RST_CURRENT_LIMIT = 16'sd250;
    localparam logic [ERR_W-1:0]   RST_MAX_ERRORS    = 4'd3;
    localparam logic [15:0]        RST_OFF_WAIT      = 16'd700;
    localparam logic [15:0]        RST_STARTUP_WAIT  = 16'd300;

    localparam logic [ERR_W-1:0]   ERR_MAX           = 4'd15;

    typedef enum logic [1:0] {
        PH_STARTUP = 2'd0,
        PH_RUN     = 2'd1,
        PH_OFF     = 2'd2,
        PH_LOCK    = 2'd3
    } phase_t;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] current_sample;
    } in_word_t;

    typedef struct packed {
        logic             motor_on;
        logic             locked_out;
        logic             trip_now;
        logic [ERR_W-1:0] error_count;
        logic [1:0]       phase_code;
    } out_word_t;

    typedef struct packed {
        logic signed [15:0] current_limit;
        logic [ERR_W-1:0]   max_consecutive_errors;
        logic [15:0]        off_wait_ticks;
        logic [15:0]        startup_wait_ticks;
    } cfg_t;

endpackage

@@ rtl/orl_cfg_regs.sv @@
// Configuration register bank of the overcurrent retry lockout block
module orl_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [orl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [orl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output orl_pkg::cfg_t                   cfg
);
    import orl_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.current_limit          <= RST_CURRENT_LIMIT;
            cfg_reg.max_consecutive_errors <= RST_MAX_ERRORS;
            cfg_reg.off_wait_ticks         <= RST_OFF_WAIT;
            cfg_reg.startup_wait_ticks     <= RST_STARTUP_WAIT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CURRENT_LIMIT: cfg_reg.current_limit <= $signed(cfg_wdata);
                CFG_MAX_ERRORS:    cfg_reg.max_consecutive_errors <= cfg_wdata[ERR_W-1:0];
                CFG_OFF_WAIT:      cfg_reg.off_wait_ticks <= cfg_wdata;
                CFG_STARTUP_WAIT:  cfg_reg.startup_wait_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/orl_step.sv @@
// Next-state and result logic for one tick or current sample
module orl_step #(
    parameter int TIMER_WIDTH = orl_pkg::TIMER_WIDTH_DEF
) (
    input  orl_pkg::in_word_t               item,
    input  orl_pkg::cfg_t                   cfg,
    input  orl_pkg::phase_t                 phase,
    input  logic [TIMER_WIDTH-1:0]          wait_cnt,
    input  logic [orl_pkg::ERR_W-1:0]       err_cnt,
    output orl_pkg::phase_t                 phase_next,
    output logic [TIMER_WIDTH-1:0]          wait_cnt_next,
    output logic [orl_pkg::ERR_W-1:0]       err_cnt_next,
    output orl_pkg::out_word_t              result
);
    import orl_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

    logic [TIMER_WIDTH-1:0] cnt_inc;
    logic [15:0]            wait_len;
    logic                   wait_done;
    logic [ERR_W-1:0]       err_inc;
    logic                   over;
    logic                   trip;

    // Saturating wait timer against the active phase's length
    assign cnt_inc   = (wait_cnt == TMAX) ? wait_cnt : wait_cnt + 1'b1;
    assign wait_len  = (phase == PH_OFF) ? cfg.off_wait_ticks : cfg.startup_wait_ticks;
    assign wait_done = (CMP_W'(cnt_inc) >= CMP_W'(wait_len)) || (cnt_inc == TMAX);

    assign err_inc = (err_cnt == ERR_MAX) ? err_cnt : err_cnt + 1'b1;
    assign over    = $signed(item.current_sample) > $signed(cfg.current_limit);
    assign trip    = item.operation && (phase == PH_RUN) && over;

    // Next state
    always_comb begin
        phase_next    = phase;
        wait_cnt_next = wait_cnt;
        err_cnt_next  = err_cnt;
        unique case (phase)
            PH_STARTUP, PH_OFF: begin
                if (!item.operation) begin
                    if (wait_done) begin
                        wait_cnt_next = '0;
                        phase_next    = (phase == PH_OFF) ? PH_STARTUP : PH_RUN;
                    end else begin
                        wait_cnt_next = cnt_inc;
                    end
                end
            end
            PH_RUN: begin
                if (item.operation) begin
                    if (over) begin
                        err_cnt_next  = err_inc;
                        wait_cnt_next = '0;
                        phase_next    = (err_inc >= cfg.max_consecutive_errors)
                                        ? PH_LOCK : PH_OFF;
                    end else begin
                        err_cnt_next = '0;
                    end
                end
            end
            PH_LOCK: ;
            default: ;
        endcase
    end

    // Result word
    always_comb begin
        result.motor_on    = (phase_next == PH_STARTUP) || (phase_next == PH_RUN);
        result.locked_out  = (phase_next == PH_LOCK);
        result.trip_now    = trip;
        result.error_count = err_cnt_next;
        result.phase_code  = phase_next;
    end

endmodule

@@ rtl/overcurrent_retry_lockout.sv @@
// Top level of the overcurrent retry lockout (hiccup) protection block
//
// Input words on s_* carry either a one-millisecond tick (operation 0) or a
// current sample (operation 1). Every accepted word yields exactly one result
// word on m_* with the drive enable, lockout flag, trip flag, consecutive
// error count and phase code after that word.
// Datapath: input register, one pass of compare/counter logic, result
// register. A word moves from the input register into the result register,
// raising m_valid, once that slot is empty or draining. Throughput is one
// word per cycle with m_ready high, set by the single state update per word.
// s_ready stays high while the result register can drain or is empty, so a
// stalled receiver fills the result register, then the input register, and
// only then drops s_ready; no word is lost or repeated.
// Reset (aresetn low, synchronous) turns the drive on in the startup wait,
// clears the timer and error count, empties both registers and restores the
// configuration defaults (limit 250, 3 errors, 700 off ticks, 300 startup).
// Configuration must be written through cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.
module overcurrent_retry_lockout #(
    parameter int TIMER_WIDTH = orl_pkg::TIMER_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  orl_pkg::in_word_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output orl_pkg::out_word_t              m_data,
    input  logic                            cfg_we,
    input  logic [orl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [orl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import orl_pkg::*;
    `include "overcurrent_retry_lockout_macros.svh"

    cfg_t                   cfg;
    in_word_t               in_data_reg;
    logic                   in_valid_reg;
    out_word_t              out_data_reg;
    logic                   out_valid_reg;
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [TIMER_WIDTH-1:0] wait_cnt_reg;
    logic [TIMER_WIDTH-1:0] wait_cnt_next;
    logic [ERR_W-1:0]       err_cnt_reg;
    logic [ERR_W-1:0]       err_cnt_next;
    out_word_t              result;
    logic                   advance;
    logic                   s_accept;

    orl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    orl_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .item          (in_data_reg),
        .cfg           (cfg),
        .phase         (phase_reg),
        .wait_cnt      (wait_cnt_reg),
        .err_cnt       (err_cnt_reg),
        .phase_next    (phase_next),
        .wait_cnt_next (wait_cnt_next),
        .err_cnt_next  (err_cnt_next),
        .result        (result)
    );

    // Move the held word into the result register when that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_STARTUP;
            wait_cnt_reg  <= '0;
            err_cnt_reg   <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                wait_cnt_reg  <= wait_cnt_next;
                err_cnt_reg   <= err_cnt_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `ORL_ASSERT_NOW(a_lock_drive_off, aclk, aresetn, m_valid && m_data.locked_out, !m_data.motor_on, "drive on while locked out")
    `ORL_ASSERT_NOW(a_trip_counts, aclk, aresetn, m_valid && m_data.trip_now, m_data.error_count != '0, "trip without error count")
    `ORL_ASSERT_NEXT(a_lock_sticky, aclk, aresetn, phase_reg == PH_LOCK, phase_reg == PH_LOCK, "left lockout without reset")
    `ORL_ASSERT_NOW(a_full_stall, aclk, aresetn, in_valid_reg && out_valid_reg && !m_ready, !s_ready, "word accepted with both registers full")

endmodule
